// ----- hw/rtl/scm_pkg.sv -----
// Package for the scored move picker: payload structs, sequencer states,
// opcodes and the score tables. Depends on nothing.
package scm_pkg;

  localparam int unsigned MAX_MOVES_DEF = 256;
  localparam int unsigned MOVE_W        = 16;
  localparam int unsigned SCORE_W       = 20;
  localparam int unsigned POS_W         = 8;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_SELECT = 2'd2;

  localparam logic [SCORE_W-1:0] TOP_SCORE = 20'd1000000;
  localparam logic [2:0]         TYPE_MAX  = 3'd5;

  localparam logic [SCORE_W-1:0] MVV_LVA [6][6] = '{
    '{20'd809000, 20'd831000, 20'd832000, 20'd849000, 20'd889000, 20'd999000},
    '{20'd806800, 20'd828800, 20'd829800, 20'd846800, 20'd886800, 20'd996800},
    '{20'd806700, 20'd828700, 20'd829700, 20'd846700, 20'd886700, 20'd996700},
    '{20'd805000, 20'd827000, 20'd828000, 20'd845000, 20'd885000, 20'd995000},
    '{20'd801000, 20'd823000, 20'd824000, 20'd841000, 20'd881000, 20'd991000},
    '{20'd799000, 20'd821000, 20'd822000, 20'd839000, 20'd879000, 20'd989000}
  };

  localparam logic [SCORE_W-1:0] PROMO_SCORES [4] = '{
    20'd790000, 20'd750000, 20'd732000, 20'd731000
  };

  typedef struct packed {
    logic [1:0]        opcode;
    logic [MOVE_W-1:0] move_word;
    logic [2:0]        attacker_type;
    logic [2:0]        victim_type;
    logic              is_capture;
    logic              is_promotion;
    logic [1:0]        promo_kind;
    logic [POS_W-1:0]  position;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [MOVE_W-1:0]  best_move;
    logic [SCORE_W-1:0] best_score;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_DONE
  } state_e;

endpackage

// ----- hw/rtl/scored_move_picker.sv -----
// Top level of the scored move picker: sequencer, shared compare unit and
// entry count. Depends on scm_pkg, scm_ram and scm_scorer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------
//  in      | input     | in_valid_i / in_stall_o | in_data_i  (in_t)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (out_t)
//  cfg     | input     | cfg_we_i               | cfg_wdata_i
//
// Clear and append are handled in the idle state without leaving it. A select at
// position p with n entries reads one entry a cycle into the shared compare unit
// and swaps with two writes; the input stalls until the sequencer is back in idle,
// and a select whose position lies past the entry count goes straight to done.
// Reset clears the entry count and control state but not the memory.
// A stalled result waits in the output register; a later select then holds in done.
module scored_move_picker #(
  parameter int unsigned MAX_MOVES = scm_pkg::MAX_MOVES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [scm_pkg::MOVE_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  scm_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output scm_pkg::out_t               out_data_o
);
  import scm_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_MOVES);
  localparam int unsigned CNT_W  = $clog2(MAX_MOVES + 1);
  localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned ENTRY_W = MOVE_W + SCORE_W;

  state_e state_q, state_d;

  logic [MOVE_W-1:0]  pref_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   scan_idx_q;
  logic [IDX_W-1:0]   pos_q;
  logic               rvalid_q;
  logic [IDX_W-1:0]   ridx_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic [MOVE_W-1:0]  best_move_q;
  logic [SCORE_W-1:0] best_score_q;
  logic [MOVE_W-1:0]  hold_move_q;
  logic [SCORE_W-1:0] hold_score_q;
  logic               found_q;
  logic               out_valid_q;
  out_t               out_q;

  logic               accept;
  logic               list_full;
  logic               pos_hit;
  logic               issue;
  logic               out_free;
  logic               take_best;
  logic [SCORE_W-1:0] app_score;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [MOVE_W-1:0]  rd_move;
  logic [SCORE_W-1:0] rd_score;

  assign accept    = in_valid_i && !in_stall_o;
  assign list_full = (count_q == CNT_W'(MAX_MOVES));
  assign pos_hit   = CMP_W'(in_data_i.position) < CMP_W'(count_q);
  assign issue     = (state_q == ST_SCAN) && (scan_idx_q < count_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign rd_move   = ram_rdata[ENTRY_W-1:SCORE_W];
  assign rd_score  = ram_rdata[SCORE_W-1:0];

  // The entry at the start position always seeds the running best, later
  // entries replace it only on a strictly higher score.
  assign take_best = rvalid_q && ((ridx_q == pos_q) || (rd_score > best_score_q));

  scm_scorer u_scorer (
    .item_i  (in_data_i),
    .pref_i  (pref_q),
    .score_o (app_score)
  );

  scm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_MOVES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_data_i.opcode == OP_SELECT)) begin
          state_d = pos_hit ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (!issue && !rvalid_q) begin
          state_d = ST_SWAP_A;
        end
      end
      ST_SWAP_A: state_d = ST_SWAP_B;
      ST_SWAP_B: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory port control and input handshake.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    ram_we     = 1'b0;
    ram_waddr  = count_q[IDX_W-1:0];
    ram_wdata  = {in_data_i.move_word, app_score};
    ram_re     = issue;
    ram_raddr  = scan_idx_q[IDX_W-1:0];
    case (state_q)
      ST_IDLE: begin
        ram_we = accept && (in_data_i.opcode == OP_APPEND) && !list_full;
      end
      ST_SWAP_A: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = {best_move_q, best_score_q};
      end
      ST_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx_q;
        ram_wdata = {hold_move_q, hold_score_q};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pref_q      <= '0;
      count_q     <= '0;
      scan_idx_q  <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= issue;
      if (cfg_we_i) begin
        pref_q <= cfg_wdata_i;
      end
      if (accept && (in_data_i.opcode == OP_CLEAR)) begin
        count_q <= '0;
      end else if (accept && (in_data_i.opcode == OP_APPEND) && !list_full) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (accept && (in_data_i.opcode == OP_SELECT)) begin
        scan_idx_q <= CNT_W'(in_data_i.position);
      end else if (issue) begin
        scan_idx_q <= scan_idx_q + CNT_W'(1);
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers of the compare unit and the result.
  always_ff @(posedge clk_i) begin
    ridx_q <= scan_idx_q[IDX_W-1:0];
    if (accept && (in_data_i.opcode == OP_SELECT)) begin
      pos_q        <= IDX_W'(in_data_i.position);
      found_q      <= pos_hit;
      best_move_q  <= '0;
      best_score_q <= '0;
    end else if (take_best) begin
      best_idx_q   <= ridx_q;
      best_move_q  <= rd_move;
      best_score_q <= rd_score;
    end
    if (rvalid_q && (ridx_q == pos_q)) begin
      hold_move_q  <= rd_move;
      hold_score_q <= rd_score;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_q.found      <= found_q;
      out_q.best_move  <= best_move_q;
      out_q.best_score <= best_score_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_MOVES))
    else $error("entry count exceeds list depth");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !ram_we)
    else $error("memory written during scan");

  a_read_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> (state_q == ST_SCAN))
    else $error("read data returned outside scan");

  a_best_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWAP_B) |-> (CNT_W'(best_idx_q) < count_q))
    else $error("best entry lies past the entry count");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside the done state");

endmodule

// ----- hw/rtl/scm_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module scm_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/scm_scorer.sv -----
// Scores one move for an append: preferred move, then capture table, then
// promotion table. Depends on scm_pkg.
module scm_scorer (
  input  scm_pkg::in_t                 item_i,
  input  logic [scm_pkg::MOVE_W-1:0]   pref_i,
  output logic [scm_pkg::SCORE_W-1:0]  score_o
);
  import scm_pkg::*;

  logic [2:0] atk_sat;
  logic [2:0] vic_sat;

  // Piece types six and seven are treated as the highest valid type.
  assign atk_sat = (item_i.attacker_type > TYPE_MAX) ? TYPE_MAX : item_i.attacker_type;
  assign vic_sat = (item_i.victim_type > TYPE_MAX) ? TYPE_MAX : item_i.victim_type;

  always_comb begin
    if (item_i.move_word == pref_i) begin
      score_o = TOP_SCORE;
    end else if (item_i.is_capture) begin
      score_o = MVV_LVA[atk_sat][vic_sat];
    end else if (item_i.is_promotion) begin
      score_o = PROMO_SCORES[item_i.promo_kind];
    end else begin
      score_o = '0;
    end
  end

endmodule
